FILE: hw/rtl/kt_pkg.sv
// shared constants and the token type for the kendall tau distance block
package kt_pkg;

  localparam int MAX_N     = 64;
  localparam int VAL_W     = 6;
  localparam int AW        = (MAX_N > 1) ? $clog2(MAX_N) : 1;
  localparam int LC_W      = $clog2(MAX_N + 1);
  localparam int BW        = (AW > VAL_W) ? AW : VAL_W;
  localparam int NCELL     = MAX_N - 1;
  localparam int OUT_W     = 11;
  localparam int TOTAL_MAX = 2047;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;

  // one composition value walking down the cell row
  typedef struct packed {
    logic             valid;
    logic             hit;
    logic [VAL_W-1:0] value;
    logic [VAL_W-1:0] count;
  } kt_tok_t;

endpackage

FILE: hw/rtl/kt_cell.sv
// one cell of the seen-value row: holds a distinct value, counts smaller ones
module kt_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            clr,
  input  kt_pkg::kt_tok_t tok_in,
  output kt_pkg::kt_tok_t tok_out
);

  logic [kt_pkg::VAL_W-1:0] held_r, held_nxt;
  logic                     full_r, full_nxt;
  kt_pkg::kt_tok_t          tok_r, tok_nxt;

  always_comb begin
    tok_nxt  = tok_in;
    held_nxt = held_r;
    full_nxt = full_r;
    if (tok_in.valid) begin
      if (full_r) begin
        if (held_r < tok_in.value) begin
          tok_nxt.count = tok_in.count + kt_pkg::VAL_W'(1);
        end
        if (held_r == tok_in.value) begin
          tok_nxt.hit = 1'b1;
        end
      end else if (!tok_in.hit) begin
        // first empty cell takes a value not seen further up the row
        held_nxt    = tok_in.value;
        full_nxt    = 1'b1;
        tok_nxt.hit = 1'b1;
      end
    end
    if (clr) begin
      full_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r      <= 1'b0;
      tok_r.valid <= 1'b0;
    end else begin
      full_r      <= full_nxt;
      tok_r.valid <= tok_nxt.valid;
    end
    held_r      <= held_nxt;
    tok_r.hit   <= tok_nxt.hit;
    tok_r.value <= tok_nxt.value;
    tok_r.count <= tok_nxt.count;
  end

  assign tok_out = tok_r;

endmodule

FILE: hw/rtl/kt_store.sv
// permutation stores: first permutation and inverse of the second, two-stage lookup
module kt_store (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     wr_en,
  input  logic [kt_pkg::AW-1:0]    wr_pos,
  input  logic [kt_pkg::VAL_W-1:0] wr_a,
  input  logic [kt_pkg::VAL_W-1:0] wr_b,
  input  logic                     rd_en,
  input  logic [kt_pkg::AW-1:0]    rd_j,
  output kt_pkg::kt_tok_t          tok
);

  logic [kt_pkg::VAL_W-1:0] a_mem   [kt_pkg::MAX_N];
  logic [kt_pkg::AW-1:0]    inv_mem [kt_pkg::MAX_N];

  logic [kt_pkg::BW-1:0]    b_ext;
  logic                     b_in_range;
  logic [kt_pkg::AW-1:0]    pos_r;
  logic [kt_pkg::VAL_W-1:0] c_r;
  logic                     v1_r, v2_r;

  assign b_ext      = kt_pkg::BW'(wr_b);
  // one extra bit so that MAX_N itself fits in the compare
  assign b_in_range = ({1'b0, b_ext} < (kt_pkg::BW + 1)'(kt_pkg::MAX_N));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      a_mem[wr_pos] <= wr_a;
      if (b_in_range) begin
        inv_mem[b_ext[kt_pkg::AW-1:0]] <= wr_pos;
      end
    end
  end

  // position of j in the second permutation, then the first permutation there
  always_ff @(posedge clk) begin
    pos_r <= inv_mem[rd_j];
    c_r   <= a_mem[pos_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= rd_en;
      v2_r <= v1_r;
    end
  end

  always_comb begin
    tok       = '0;
    tok.valid = v2_r;
    tok.value = c_r;
  end

endmodule

FILE: hw/rtl/kendall_tau_distance_top.sv
// kendall tau distance top: load control, cell row and saturating total
//
// channel | dir | tdata (low bit up)              | tlast
// in_     | in  | a_value[5:0], b_value[11:6]     | is_last
// out_    | out | distance[10:0]                  | -
//
// loading takes one word per cycle; the word with tlast closes the load.
// after the last word the total is built from n - 1 lookups issued one a cycle,
// the store's position and value registers, the walk through the MAX_N - 1 cells
// and the total register, and then moves into the output register.
// in_tready is low from the last word until the result enters the output
// register; a waiting result does not stop the next load.
// reset clears control state; the permutation stores are left as they are.
module kendall_tau_distance_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [kt_pkg::IN_TDATA_W-1:0]  in_tdata,   // a_value, b_value
  input  logic                           in_tlast,   // is_last
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [kt_pkg::OUT_TDATA_W-1:0] out_tdata   // distance
);

  typedef enum logic {S_LOAD, S_RUN} state_t;

  state_t                    state_r, state_nxt;
  logic [kt_pkg::LC_W-1:0]   lcount_r, lcount_nxt;
  logic [kt_pkg::AW-1:0]     ntok_r, ntok_nxt;
  logic [kt_pkg::AW-1:0]     issue_r, issue_nxt;
  logic [kt_pkg::AW-1:0]     exit_r, exit_nxt;
  logic [kt_pkg::OUT_W-1:0]  total_r, total_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [kt_pkg::OUT_W-1:0]  out_dist_r, out_dist_nxt;

  logic                      in_acc;
  logic                      wr_en;
  logic                      rd_en;
  logic                      clr;
  logic [kt_pkg::VAL_W-1:0]  term;
  logic [kt_pkg::OUT_W:0]    sum;
  kt_pkg::kt_tok_t           chain [kt_pkg::NCELL+1];

  assign in_tready = (state_r == S_LOAD);
  assign in_acc    = in_tvalid && in_tready;
  assign wr_en     = in_acc && (lcount_r < kt_pkg::LC_W'(kt_pkg::MAX_N));
  assign rd_en     = (state_r == S_RUN) && (issue_r < ntok_r);
  assign clr       = in_acc && in_tlast;

  kt_store u_store (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (wr_en),
    .wr_pos (lcount_r[kt_pkg::AW-1:0]),
    .wr_a   (in_tdata[kt_pkg::VAL_W-1:0]),
    .wr_b   (in_tdata[2*kt_pkg::VAL_W-1:kt_pkg::VAL_W]),
    .rd_en  (rd_en),
    .rd_j   (issue_r),
    .tok    (chain[0])
  );

  for (genvar i = 0; i < kt_pkg::NCELL; i++) begin : g_cell
    kt_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .clr     (clr),
      .tok_in  (chain[i]),
      .tok_out (chain[i+1])
    );
  end

  // term is c minus the distinct smaller values seen before it
  assign term = chain[kt_pkg::NCELL].value - chain[kt_pkg::NCELL].count;
  assign sum  = {1'b0, total_r} + (kt_pkg::OUT_W + 1)'(term);

  always_comb begin
    state_nxt     = state_r;
    lcount_nxt    = lcount_r;
    ntok_nxt      = ntok_r;
    issue_nxt     = issue_r;
    exit_nxt      = exit_r;
    total_nxt     = total_r;
    out_valid_nxt = out_valid_r;
    out_dist_nxt  = out_dist_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_LOAD: begin
        if (in_acc) begin
          if (wr_en) begin
            lcount_nxt = lcount_r + kt_pkg::LC_W'(1);
          end
          if (in_tlast) begin
            if (wr_en) begin
              ntok_nxt = lcount_r[kt_pkg::AW-1:0];
            end else begin
              ntok_nxt = kt_pkg::AW'(kt_pkg::MAX_N - 1);
            end
            lcount_nxt = '0;
            issue_nxt  = '0;
            exit_nxt   = '0;
            total_nxt  = '0;
            state_nxt  = S_RUN;
          end
        end
      end
      S_RUN: begin
        if (rd_en) begin
          issue_nxt = issue_r + kt_pkg::AW'(1);
        end
        if (chain[kt_pkg::NCELL].valid) begin
          exit_nxt = exit_r + kt_pkg::AW'(1);
          if (sum > (kt_pkg::OUT_W + 1)'(kt_pkg::TOTAL_MAX)) begin
            total_nxt = kt_pkg::OUT_W'(kt_pkg::TOTAL_MAX);
          end else begin
            total_nxt = sum[kt_pkg::OUT_W-1:0];
          end
        end
        if ((exit_r == ntok_r) && (!out_valid_r || out_tready)) begin
          out_valid_nxt = 1'b1;
          out_dist_nxt  = total_r;
          state_nxt     = S_LOAD;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      lcount_r    <= '0;
      ntok_r      <= '0;
      issue_r     <= '0;
      exit_r      <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lcount_r    <= lcount_nxt;
      ntok_r      <= ntok_nxt;
      issue_r     <= issue_nxt;
      exit_r      <= exit_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_dist_r <= out_dist_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = kt_pkg::OUT_TDATA_W'(out_dist_r);

  a_exit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN) |-> (exit_r <= ntok_r))
    else $error("more tokens left the cell row than were issued");

  a_exit_after_issue: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN) |-> (exit_r <= issue_r))
    else $error("token left the cell row before it was issued");

  a_row_idle_in_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOAD) |-> !chain[kt_pkg::NCELL].valid)
    else $error("token reached the end of the row while loading");

endmodule
